// ===== rtl/core/ines_header_parser_core_defines.svh =====
// Assertion macros used by the checker of the header parser.
`ifndef INES_HEADER_PARSER_CORE_DEFINES_SVH
`define INES_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define IHP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("header parser assertion failed");

// Next-cycle implication, disabled while reset is active.
`define IHP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("header parser assertion failed");

`endif

// ===== rtl/core/ihp_pkg.sv =====
`timescale 1ns / 1ps
package ihp_pkg;

	// Header geometry.
	localparam int unsigned HDR_LEN     = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Header variants.
	typedef enum logic [1:0] {
		VAR_INVALID = 2'd0,
		VAR_ARCHAIC = 2'd1,
		VAR_INES    = 2'd2,
		VAR_NES2    = 2'd3
	} hdr_var_t;

	// Field codes of the result stream.
	localparam logic [4:0] FLD_VARIANT   = 5'd0;
	localparam logic [4:0] FLD_FLAGS     = 5'd1;
	localparam logic [4:0] FLD_MAPPER    = 5'd2;
	localparam logic [4:0] FLD_SUBMAPPER = 5'd3;
	localparam logic [4:0] FLD_PRG       = 5'd4;
	localparam logic [4:0] FLD_CHR       = 5'd5;
	localparam logic [4:0] FLD_PRG_RAM   = 5'd6;
	localparam logic [4:0] FLD_PRG_NVRAM = 5'd7;
	localparam logic [4:0] FLD_CHR_RAM   = 5'd8;
	localparam logic [4:0] FLD_CHR_NVRAM = 5'd9;
	localparam logic [4:0] FLD_TIMING    = 5'd10;
	localparam logic [4:0] FLD_CONSOLE   = 5'd11;
	localparam logic [4:0] FLD_VS_PPU    = 5'd12;
	localparam logic [4:0] FLD_VS_HW     = 5'd13;
	localparam logic [4:0] FLD_EXT_CON   = 5'd14;
	localparam logic [4:0] FLD_MISC_ROMS = 5'd15;
	localparam logic [4:0] FLD_EXPANSION = 5'd16;
	localparam logic [4:0] FLD_LAST      = FLD_EXPANSION;

	// Console type codes found in byte 7.
	localparam logic [1:0] CON_VS       = 2'd1;
	localparam logic [1:0] CON_EXTENDED = 2'd3;

	// Magic bytes and the archaic filler text.
	localparam logic [7:0] MAGIC0 = 8'h4E;
	localparam logic [7:0] MAGIC1 = 8'h45;
	localparam logic [7:0] MAGIC2 = 8'h53;
	localparam logic [7:0] MAGIC3 = 8'h1A;
	localparam logic [8:0][7:0] DISK_TEXT = {
		8'h21, 8'h65, 8'h64, 8'h75, 8'h44, 8'h6B, 8'h73, 8'h69, 8'h44
	};

	// Version detection in byte 7.
	localparam logic [7:0] VER_MASK  = 8'h0C;
	localparam logic [7:0] VER_NES2  = 8'h08;

	// RAM size base in bytes, scaled by the shift count.
	localparam logic [21:0] RAM_BASE = 22'd64;

	// Payload types.
	typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       first_byte;
	} ihp_in_t;

	typedef struct packed {
		logic [4:0]  field_code;
		logic [21:0] field_value;
		logic        last_field;
	} ihp_out_t;

	typedef struct packed {
		hdr_var_t   variant;
		hdr_bytes_t bytes;
	} hdr_entry_t;

	// Memory size in bytes from a 4-bit shift count.
	function automatic logic [21:0] ram_bytes(input logic [3:0] s);
		ram_bytes = (s == 4'd0) ? 22'd0 : (RAM_BASE << s);
	endfunction

	// Value of one field of a classified header.
	function automatic logic [21:0] field_value(input hdr_entry_t e, input logic [4:0] code);
		logic       valid;
		logic       ines_up;
		logic       nes2;
		logic       ines;
		logic [1:0] console;
		hdr_bytes_t h;
		logic [21:0] v;
		h       = e.bytes;
		valid   = (e.variant != VAR_INVALID);
		nes2    = (e.variant == VAR_NES2);
		ines    = (e.variant == VAR_INES);
		ines_up = nes2 || ines;
		console = h[7][1:0];
		v       = '0;
		unique case (code)
			FLD_VARIANT:   v = {20'd0, e.variant};
			FLD_FLAGS:     if (valid) v = {18'd0, h[6][3:0]};
			FLD_MAPPER: begin
				if (valid)   v[3:0]  = h[6][7:4];
				if (ines_up) v[7:4]  = h[7][7:4];
				if (nes2)    v[11:8] = h[8][3:0];
			end
			FLD_SUBMAPPER: if (nes2) v = {18'd0, h[8][7:4]};
			FLD_PRG: begin
				if (valid) v[7:0]  = h[4];
				if (nes2)  v[11:8] = h[9][3:0];
			end
			FLD_CHR: begin
				if (valid) v[7:0]  = h[5];
				if (nes2)  v[11:8] = h[9][7:4];
			end
			FLD_PRG_RAM: begin
				if (ines)      v = {1'b0, h[8], 13'd0};
				else if (nes2) v = ram_bytes(h[10][3:0]);
			end
			FLD_PRG_NVRAM: if (nes2) v = ram_bytes(h[10][7:4]);
			FLD_CHR_RAM:   if (nes2) v = ram_bytes(h[11][3:0]);
			FLD_CHR_NVRAM: if (nes2) v = ram_bytes(h[11][7:4]);
			FLD_TIMING: begin
				if (ines)      v = {21'd0, h[9][0]};
				else if (nes2) v = {20'd0, h[12][1:0]};
			end
			FLD_CONSOLE:   if (ines_up) v = {20'd0, console};
			FLD_VS_PPU:    if (nes2 && console == CON_VS) v = {18'd0, h[13][3:0]};
			FLD_VS_HW:     if (nes2 && console == CON_VS) v = {18'd0, h[13][7:4]};
			FLD_EXT_CON:   if (nes2 && console == CON_EXTENDED) v = {18'd0, h[13][3:0]};
			FLD_MISC_ROMS: if (nes2) v = {20'd0, h[14][1:0]};
			FLD_EXPANSION: if (nes2) v = {16'd0, h[15][5:0]};
			default:       v = '0;
		endcase
		field_value = v;
	endfunction

endpackage

// ===== rtl/core/ines_header_parser_core.sv =====
`timescale 1ns / 1ps
// Cartridge header parser for iNES and NES 2.0 images.
// Input channel: one header byte per request with a start mark on byte 0;
// a start mark restarts the byte count, and bytes after the sixteenth are
// dropped until the next start mark.
// Output channel: after the sixteenth byte, 17 tagged field results in code
// order 0 to 16; the last one carries last_field.
// The sixteenth byte is written into the header queue; the results are then
// decoded one by one from the queue head into the output register.
// Throughput: bytes are taken one per cycle while the queue has room; the
// output side emits one field per cycle while the receiver does not stall,
// set by the single field decoder that serves one field per cycle.
// A two-entry header queue decouples the two sides: the input stalls only
// while both entries are occupied, so a stalled receiver holds off new
// bytes after at most two further headers have been collected.
// When the receiver stalls, the current result stays registered and stable.
// Reset clears the byte count, the queue and the output valid; no result is
// pending afterwards and the next byte is counted as byte 0.
module ines_header_parser_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ihp_pkg::ihp_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output ihp_pkg::ihp_out_t out_item
);

	logic                queue_full;
	logic                push;
	ihp_pkg::hdr_entry_t push_entry;
	logic                pop;
	logic                not_empty;
	ihp_pkg::hdr_entry_t head;

	// Byte collection and classification.
	ihp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Header queue between the two sides.
	ihp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Field decode and result output.
	ihp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/core/ihp_front.sv =====
`timescale 1ns / 1ps
module ihp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ihp_pkg::ihp_in_t    in_item,
	input  logic                queue_full,
	output logic                push,
	output ihp_pkg::hdr_entry_t push_entry
);

	localparam int unsigned STORE_LEN = ihp_pkg::HDR_LEN - 1;

	logic [4:0] count_q;
	logic [7:0] store_q [STORE_LEN];
	logic [4:0] eff_count;
	logic       take;
	logic       byte_used;
	logic       is_last_byte;
	ihp_pkg::hdr_bytes_t hdr;
	logic       magic_ok;
	logic       archaic;

	// A request is held off while the queue has no room for a header.
	assign in_stall     = queue_full;
	assign take         = in_valid && !in_stall;
	assign eff_count    = in_item.first_byte ? 5'd0 : count_q;
	assign byte_used    = !eff_count[4];
	assign is_last_byte = (eff_count == 5'(STORE_LEN));
	assign push         = take && byte_used && is_last_byte;

	// Assemble the full header from the stored bytes and the arriving one.
	always_comb begin
		for (int i = 0; i < STORE_LEN; i++) begin
			hdr[i] = store_q[i];
		end
		hdr[STORE_LEN] = in_item.header_byte;
	end

	// Classify the header on the fly as its last byte arrives.
	always_comb begin
		magic_ok = (hdr[0] == ihp_pkg::MAGIC0) && (hdr[1] == ihp_pkg::MAGIC1) &&
			(hdr[2] == ihp_pkg::MAGIC2) && (hdr[3] == ihp_pkg::MAGIC3);
		archaic = 1'b1;
		for (int i = 0; i < 9; i++) begin
			if (hdr[7 + i] != 8'd0 && hdr[7 + i] != ihp_pkg::DISK_TEXT[i]) begin
				archaic = 1'b0;
			end
		end
		push_entry.bytes = hdr;
		priority if (!magic_ok) begin
			push_entry.variant = ihp_pkg::VAR_INVALID;
		end else if (archaic) begin
			push_entry.variant = ihp_pkg::VAR_ARCHAIC;
		end else if ((hdr[7] & ihp_pkg::VER_MASK) == ihp_pkg::VER_NES2) begin
			push_entry.variant = ihp_pkg::VAR_NES2;
		end else begin
			push_entry.variant = ihp_pkg::VAR_INES;
		end
	end

	// Byte counter; a start mark restarts it, bytes past the header are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd0;
		end else if (take) begin
			count_q <= byte_used ? (eff_count + 5'd1) : eff_count;
		end
	end

	// Header byte store; the last byte goes straight into the queue.
	always_ff @(posedge clk) begin
		if (take && byte_used && !is_last_byte) begin
			store_q[eff_count[3:0]] <= in_item.header_byte;
		end
	end

endmodule

// ===== rtl/core/ihp_queue.sv =====
`timescale 1ns / 1ps
module ihp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ihp_pkg::hdr_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output ihp_pkg::hdr_entry_t head
);

	localparam int unsigned DEPTH  = ihp_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	ihp_pkg::hdr_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Header storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/ihp_back.sv =====
`timescale 1ns / 1ps
module ihp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  ihp_pkg::hdr_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output ihp_pkg::ihp_out_t   out_item
);

	logic [4:0]        emit_q;
	logic              out_valid_q;
	ihp_pkg::ihp_out_t out_item_q;
	logic              advance;
	logic              load;
	logic              at_last;

	assign advance   = !out_valid_q || !out_stall;
	assign load      = advance && not_empty;
	assign at_last   = (emit_q == ihp_pkg::FLD_LAST);
	assign pop       = load && at_last;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Field index and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= not_empty;
			end
			if (load) begin
				emit_q <= at_last ? 5'd0 : emit_q + 5'd1;
			end
		end
	end

	// Decode one field of the head header into the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.field_code  <= emit_q;
			out_item_q.field_value <= ihp_pkg::field_value(head, emit_q);
			out_item_q.last_field  <= at_last;
		end
	end

endmodule

// ===== rtl/core/ihp_checker.sv =====
`timescale 1ns / 1ps
`include "ines_header_parser_core_defines.svh"
module ihp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input ihp_pkg::ihp_in_t  in_item,
	input logic              out_valid,
	input logic              out_stall,
	input ihp_pkg::ihp_out_t out_item
);

	logic [4:0] exp_code_q;
	logic       out_take;
	logic       in_idle;

	assign out_take = out_valid && !out_stall;
	assign in_idle  = !in_valid || in_stall || !in_item.first_byte || in_item.first_byte;

	// Field code that the next result must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_code_q <= 5'd0;
		end else if (out_take) begin
			exp_code_q <= (out_item.field_code == ihp_pkg::FLD_LAST) ? 5'd0 :
				out_item.field_code + 5'd1;
		end
	end

	`IHP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`IHP_ASSERT_IMP(a_code_order, clk, arst_n, out_valid && in_idle, out_item.field_code == exp_code_q)
	`IHP_ASSERT_IMP(a_last_flag, clk, arst_n, out_valid, out_item.last_field == (out_item.field_code == ihp_pkg::FLD_LAST))
	`IHP_ASSERT_IMP(a_variant_rng, clk, arst_n, out_valid && out_item.field_code == ihp_pkg::FLD_VARIANT, out_item.field_value < 22'd4)

endmodule

bind ines_header_parser_core ihp_checker u_ihp_checker (.*);
